// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the rtl decoder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// when the antecedent holds, the consequent holds in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// when the antecedent holds, the consequent holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/uleb_pkg.sv =====
`default_nettype none

package uleb_pkg;

  // default decoded value width
  localparam int VALUE_WIDTH_DEF = 64;

  // encoded byte layout
  localparam int CHUNK_BITS = 7;
  localparam int CONT_BIT   = 7;

  // byte index / count width, enough for the widest value plus one overflow byte
  localparam int IDX_W = 4;

  // shift amount width, holds index times chunk bits
  localparam int SHIFT_W = 7;

  // input item kind
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NONCANON = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uleb128_stream_decoder_unit.sv =====
// channel | direction | tdata                      | tuser
// s_*     | in        | byte_in[7:0]               | cmd[0]
// m_*     | out       | value, byte_count, zero pad| status[1:0]
//
// one byte per cycle sustained; an item passes through the input register,
// then its result, if any, sits in the output register until taken.
// the accumulator and byte index update in the same cycle an item leaves the input register.
// continuation bytes keep moving while a result waits downstream; only a byte that
// ends a value, an error or an end marker waits for the output register to free up.
// synchronous active-high reset clears the valid flags, accumulator and byte index.
`default_nettype none
`include "assert_macros.svh"

module uleb128_stream_decoder_unit
  import uleb_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // slave side
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [7:0]              s_tdata,  // byte_in[7:0]
  input  wire logic [0:0]              s_tuser,  // cmd[0]
  // master side
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // value[VALUE_WIDTH-1:0], byte_count[IDX_W-1:0], zero pad to whole bytes
  output logic [((VALUE_WIDTH+IDX_W+7)/8)*8-1:0] m_tdata,
  output logic [1:0]                   m_tuser   // status[1:0]
);

  localparam int OutDataW = ((VALUE_WIDTH + IDX_W + 7) / 8) * 8;
  localparam int MaxIdx   = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int WideW    = VALUE_WIDTH + CHUNK_BITS;

  // input register
  logic                   in_valid;
  cmd_t                   in_cmd;
  logic [7:0]             in_byte;

  // decode state
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] acc_next;
  logic [IDX_W-1:0]       byte_index;
  logic [IDX_W-1:0]       byte_index_next;

  // output register
  status_t                out_status;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [IDX_W-1:0]       out_count;

  // decode signals
  logic [SHIFT_W-1:0]     shift;
  logic [CHUNK_BITS-1:0]  payload;
  logic                   last;
  logic [WideW-1:0]       placed;
  logic                   ovf;
  logic [VALUE_WIDTH-1:0] merged;
  logic                   emit;
  status_t                res_status;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [IDX_W-1:0]       res_count;
  logic                   advance;

  // payload placement and overflow check
  always_comb begin
    shift   = SHIFT_W'(byte_index) * SHIFT_W'(CHUNK_BITS);
    payload = in_byte[CHUNK_BITS-1:0];
    last    = ~in_byte[CONT_BIT];
    placed  = WideW'(payload) << shift;
    ovf     = (shift >= SHIFT_W'(VALUE_WIDTH)) || (|placed[WideW-1:VALUE_WIDTH]);
    merged  = acc | placed[VALUE_WIDTH-1:0];
  end

  // result selection and next state
  always_comb begin
    emit            = 1'b0;
    res_status      = ST_OK;
    res_value       = '0;
    res_count       = byte_index + IDX_W'(1);
    acc_next        = acc;
    byte_index_next = byte_index;
    if (in_cmd == CMD_END) begin
      emit       = 1'b1;
      res_status = ST_TRUNC;
      res_count  = byte_index;
    end else if (ovf) begin
      emit       = 1'b1;
      res_status = ST_OVERFLOW;
    end else if (last && (shift != '0) && (payload == '0)) begin
      emit       = 1'b1;
      res_status = ST_NONCANON;
    end else if (last) begin
      emit       = 1'b1;
      res_status = ST_OK;
      res_value  = merged;
    end else begin
      acc_next        = merged;
      byte_index_next = byte_index + IDX_W'(1);
    end
    if (emit) begin
      acc_next        = '0;
      byte_index_next = '0;
    end
  end

  // an item leaves the input register when its result has room or it makes none
  assign advance  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= cmd_t'(s_tuser[0]);
      in_byte <= s_tdata;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      byte_index <= '0;
    end else if (advance) begin
      acc        <= acc_next;
      byte_index <= byte_index_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= res_count;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = OutDataW'({out_count, out_value});

  // checks
  `ASSERT_ALWAYS(a_idx_range, byte_index <= IDX_W'(MaxIdx), "byte index past last legal byte")
  `ASSERT_NEXT(a_emit_shown, advance && emit, m_tvalid, "result lost on its way out")
  `ASSERT_IMPLY(a_err_zero, m_tvalid && (out_status != ST_OK), out_value == '0,
                "error result carries a nonzero value")
  `ASSERT_IMPLY(a_ok_count, m_tvalid && (out_status == ST_OK), out_count != '0,
                "ok result with zero byte count")

endmodule

`default_nettype wire

// ===== tb/sv/uleb128_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module uleb128_stream_decoder_unit_tb;
  import uleb_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int TDATA_W     = ((VW + IDX_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1200;

  // decoded-value scoreboard: tracks the partial value and queues the results it implies
  class uleb_decode_board;
    typedef struct {
      status_t              status;
      logic [VW-1:0]        value;
      logic [IDX_W-1:0]     count;
    } decoded_t;

    decoded_t            expected_values[$];
    logic [VW-1:0]       partial_value;
    logic [IDX_W-1:0]    bytes_taken;
    int                  mismatches;
    int                  checked;
    int                  per_status[4];

    function new();
      partial_value = '0;
      bytes_taken   = '0;
      mismatches    = 0;
      checked       = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    function void finish_value(status_t st, logic [VW-1:0] v, logic [IDX_W-1:0] n);
      decoded_t d;
      d.status = st;
      d.value  = v;
      d.count  = n;
      expected_values.push_back(d);
      partial_value = '0;
      bytes_taken   = '0;
    endfunction

    // note one accepted input transfer
    function void take_byte(cmd_t cmd, logic [7:0] b);
      int               shift;
      logic [6:0]       payload;
      logic             last;
      logic [IDX_W-1:0] count;
      payload = b[6:0];
      last    = !b[CONT_BIT];
      shift   = int'(bytes_taken) * CHUNK_BITS;
      count   = bytes_taken + 1'b1;
      if (cmd == CMD_END) begin
        finish_value(ST_TRUNC, '0, bytes_taken);
      end else if (shift >= VW) begin
        finish_value(ST_OVERFLOW, '0, count);
      end else if (shift + CHUNK_BITS > VW && (payload >> (VW - shift)) != 0) begin
        // top chunk carries bits past the value width
        finish_value(ST_OVERFLOW, '0, count);
      end else if (last && shift != 0 && payload == 0) begin
        // trailing zero chunk: non-canonical encoding
        finish_value(ST_NONCANON, '0, count);
      end else begin
        partial_value = partial_value | ({{(VW-7){1'b0}}, payload} << shift);
        if (last) begin
          finish_value(ST_OK, partial_value, count);
        end else begin
          bytes_taken = count;
        end
      end
    endfunction

    task flag(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one accepted output transfer with the oldest expectation
    task check_result(status_t st, logic [VW-1:0] v, logic [IDX_W-1:0] n);
      decoded_t d;
      if (expected_values.size() == 0) begin
        flag($sformatf("unexpected result status=%0d value=%0h count=%0d", st, v, n));
      end else begin
        d = expected_values.pop_front();
        checked++;
        per_status[d.status]++;
        if (st !== d.status)
          flag($sformatf("status %0d, expected %0d", st, d.status));
        if (v !== d.value)
          flag($sformatf("value %0h, expected %0h", v, d.value));
        if (n !== d.count)
          flag($sformatf("byte_count %0d, expected %0d", n, d.count));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;   // byte_in[7:0]
  logic [0:0]         s_tuser = '0;   // cmd[0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;        // value, byte_count, zero pad
  logic [1:0]         m_tuser;        // status[1:0]

  uleb_decode_board board = new();
  int  items_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  hold_ask = 0;
  int  hold_left = 0;

  uleb128_stream_decoder_unit #(.VALUE_WIDTH(VW)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               board.expected_values.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check transfers, then pick tready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(status_t'(m_tuser), m_tdata[VW-1:0], m_tdata[VW +: IDX_W]);
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // offer one item and wait for its transfer
  task automatic send_byte(cmd_t cmd, logic [7:0] b);
    // one idle cycle ahead of about a quarter of the items keeps the idle share near 21%
    if (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_byte(cmd, b);
    items_sent++;
  endtask

  // one encoded value with random length and payload, sometimes broken
  task automatic send_random_value();
    int         len;
    int         r;
    logic [6:0] pl;
    r = $urandom_range(99);
    if (r < 10) begin
      // noise
      send_byte(cmd_t'($urandom_range(1)), 8'($urandom_range(255)));
    end else begin
      r = $urandom_range(99);
      if (r < 50)      len = $urandom_range(1, 3);
      else if (r < 80) len = $urandom_range(4, 8);
      else if (r < 95) len = $urandom_range(9, 10);
      else             len = $urandom_range(11, 12);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 10)      pl = 7'h00;
        else if (r < 20) pl = 7'h7f;
        else             pl = 7'($urandom_range(127));
        // tenth chunk is mostly legal, sometimes too wide
        if (i == 9 && $urandom_range(99) < 70) pl = 7'($urandom_range(1));
        if (i < len - 1) begin
          send_byte(CMD_DATA, {1'b1, pl});
        end else begin
          r = $urandom_range(99);
          if (r < 8) begin
            send_byte(CMD_END, 8'($urandom_range(255)));
          end else begin
            if (i > 0 && r < 88 && pl == 0) pl = 7'h01;
            if (i > 0 && r >= 94) pl = 7'h00;
            send_byte(CMD_DATA, {1'b0, pl});
          end
        end
      end
    end
  endtask

  // stop offering until every expected result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_values.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single-byte values at both ends
    send_byte(CMD_DATA, 8'h00);
    send_byte(CMD_DATA, 8'h7f);
    // trailing zero chunk
    send_byte(CMD_DATA, 8'h80);
    send_byte(CMD_DATA, 8'h00);
    // end marker with and without a value in progress
    send_byte(CMD_END, 8'hff);
    send_byte(CMD_DATA, 8'hff);
    send_byte(CMD_END, 8'h00);
    // largest value: nine full chunks and a one
    repeat (9) send_byte(CMD_DATA, 8'hff);
    send_byte(CMD_DATA, 8'h01);
    // an eleventh byte always overflows
    repeat (9) send_byte(CMD_DATA, 8'h80);
    send_byte(CMD_DATA, 8'h81);
    send_byte(CMD_DATA, 8'h00);

    // random values, with idling on both sides
    while (items_sent < RANDOM_ITEMS / 3) send_random_value();
    // stretch with no idling
    calm = 1'b1;
    while (items_sent < RANDOM_ITEMS / 2) send_random_value();
    calm = 1'b0;
    // receiver holds off while input keeps coming
    hold_ask = 300;
    while (items_sent < (RANDOM_ITEMS * 3) / 4) send_random_value();
    drain_results();
    while (items_sent < RANDOM_ITEMS) send_random_value();

    drain_results();
    repeat (12) @(posedge clk);

    $display("decoded %0d results from %0d input transfers", board.checked, items_sent);
    $display("ok %0d, overflow %0d, non-canonical %0d, truncated %0d",
             board.per_status[ST_OK], board.per_status[ST_OVERFLOW],
             board.per_status[ST_NONCANON], board.per_status[ST_TRUNC]);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
